// ===== rtl/stereo_rms_compressor_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef STEREO_RMS_COMPRESSOR_ASSERT_SVH
`define STEREO_RMS_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stereo_rms_compressor: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stereo_rms_compressor: assertion failed");

// Next-cycle implication that is also checked across reset.
`define SRC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("stereo_rms_compressor: assertion failed");

`endif

// ===== rtl/scr_pkg.sv =====
`timescale 1ns / 1ps

package scr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 32;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int LOG_W    = 5 + FRAC_W;
    localparam int ATT_W    = 23;

    localparam logic [23:0]      ENV_ONE     = 24'h80_0000;
    localparam logic [ATT_W-1:0] ATT_MAX     = 23'h40_0000;
    localparam logic [LOG_W-1:0] ENV_LOG_ONE = LOG_W'(23 << FRAC_W);

    localparam logic [15:0] RST_ALPHA     = 16'd65000;
    localparam logic [15:0] RST_WEIGHT    = 16'd134;
    localparam logic [15:0] RST_THRESHOLD = 16'd16384;
    localparam logic [15:0] RST_RATIO     = 16'd16384;
    localparam logic [15:0] RST_ATTACK    = 16'd6554;
    localparam logic [15:0] RST_RELEASE   = 16'd66;
    localparam logic [15:0] RST_MAKEUP    = 16'd4096;

    typedef enum logic [2:0] {
        CFG_ALPHA,
        CFG_WEIGHT,
        CFG_THRESHOLD,
        CFG_RATIO,
        CFG_ATTACK,
        CFG_RELEASE,
        CFG_MAKEUP
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_AHI, S_ALO, S_MONO, S_WT, S_SUM, S_SQRT,
        S_LGN, S_LGS, S_LGD, S_ATT, S_ENVCHK, S_MIX1, S_MIX2,
        S_EXP, S_SHIFT, S_GAIN, S_OUTL, S_OUTR, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        LG_LEV,
        LG_THR,
        LG_ENV
    } lg_sel_t;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] weight;
        logic [15:0] threshold;
        logic [15:0] ratio;
        logic [15:0] attack;
        logic [15:0] release_c;
        logic [15:0] makeup;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic [15:0]         envelope;
    } res_t;

    typedef logic [15:0][31:0] exp_tab_t;

    function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Entry i holds 2^-(2^-(i+1)) in Q0.32, each derived from the one before.
    function automatic exp_tab_t exp_table();
        exp_tab_t    t;
        logic [63:0] c;
        c = isqrt_const(64'h8000_0000_0000_0000);
        for (int i = 0; i < 16; i++) begin
            t[i] = c[31:0];
            c    = isqrt_const({c[31:0], 32'd0});
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_C = exp_table();

endpackage

// ===== rtl/stereo_rms_compressor.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// s_       | s_valid, s_ready     | s_left_in, s_right_in
// m_       | m_valid, m_ready     | m_left_out, m_right_out, m_envelope_out
// cfg_     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// The square root and up to three log passes plus the 16-step exponent set how long a
// sample pair takes from its accepting edge until m_valid rises; the log passes and the
// exponent share one multiplier. s_ready is low while a pair is in work. A finished
// result waits in the core until the output register has room; the next pair may enter then.
// Reset is synchronous and active low and restores level, envelope and configuration registers.

module stereo_rms_compressor
    import scr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_left_in,
    input  logic [SAMPLE_W-1:0] s_right_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_left_out,
    output logic [SAMPLE_W-1:0] m_right_out,
    output logic [15:0]         m_envelope_out,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    cfg_t cfg_reg;
    res_t core_res, res_reg;
    logic core_idle, core_res_valid, res_take;
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha     <= RST_ALPHA;
            cfg_reg.weight    <= RST_WEIGHT;
            cfg_reg.threshold <= RST_THRESHOLD;
            cfg_reg.ratio     <= RST_RATIO;
            cfg_reg.attack    <= RST_ATTACK;
            cfg_reg.release_c <= RST_RELEASE;
            cfg_reg.makeup    <= RST_MAKEUP;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ALPHA:     cfg_reg.alpha     <= cfg_data;
                CFG_WEIGHT:    cfg_reg.weight    <= cfg_data;
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data;
                CFG_RATIO:     cfg_reg.ratio     <= cfg_data;
                CFG_ATTACK:    cfg_reg.attack    <= cfg_data;
                CFG_RELEASE:   cfg_reg.release_c <= cfg_data;
                CFG_MAKEUP:    cfg_reg.makeup    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    scr_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && s_ready),
        .left_in  (s_left_in),
        .right_in (s_right_in),
        .cfg      (cfg_reg),
        .idle     (core_idle),
        .res_valid(core_res_valid),
        .res_take (res_take),
        .res      (core_res)
    );

    // The core holds its result until the output register has room.
    assign res_take = core_res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            res_reg <= core_res;
        end
    end

    assign s_ready        = core_idle;
    assign m_valid        = m_valid_reg;
    assign m_left_out     = res_reg.left;
    assign m_right_out    = res_reg.right;
    assign m_envelope_out = res_reg.envelope;

endmodule

// ===== rtl/scr_mul.sv =====
`timescale 1ns / 1ps

module scr_mul
    import scr_pkg::*;
(
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] p
);

    assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

// ===== rtl/scr_isqrt.sv =====
`timescale 1ns / 1ps

module scr_isqrt
    import scr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg, res_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg, done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // One restoring step per cycle, two radicand bits at a time.
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (run_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== rtl/scr_core.sv =====
`timescale 1ns / 1ps

module scr_core
    import scr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] left_in,
    input  logic [SAMPLE_W-1:0] right_in,
    input  cfg_t                cfg,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_take,
    output res_t                res
);

    state_t  state_reg, state_next;
    lg_sel_t lg_sel_reg;

    logic [31:0]      dl_reg;
    logic [23:0]      env_reg;
    logic [63:0]      acc_reg, t_reg;
    logic [4:0]       cnt_reg;
    logic [31:0]      lgx_reg, m_reg;
    logic [4:0]       lgn_reg;
    logic [15:0]      frac_reg;
    logic [LOG_W-1:0] ll_reg;
    logic [ATT_W-1:0] at_reg, ae_reg, anew_reg;
    logic [32:0]      r_reg;
    logic [15:0]      g_reg, env16_reg;
    logic [MAG_W-1:0] ml_reg, mr_reg, mono_reg;
    logic             nl_reg, nr_reg;
    logic [SAMPLE_W-1:0] out_l_reg, out_r_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [63:0]        prod;

    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic [64:0] sum65;
    logic [16:0] thr16;
    logic [16:0] one_minus_q, one_minus_c;
    logic [15:0] coef;
    logic [31:0] nx;
    logic [4:0]  nn;
    logic [31:0] q;
    logic [LOG_W-1:0] lgr;
    logic [40:0] mix_sum;
    logic [32:0] r_shift;
    logic [23:0] env_raw, env_new;
    logic [16:0] e16;
    logic [MAG_W-1:0] mag_l, mag_r, mono_in;
    logic [MAG_W-1:0] pair_sum;

    function automatic logic [SAMPLE_W-1:0] sat_out(input logic [19:0] y, input logic neg);
        logic [19:0] lim;
        if (neg) begin
            lim = (y > 20'd32768) ? 20'd32768 : y;
            return SAMPLE_W'(20'd0 - lim);
        end
        return (y > 20'd32767) ? 16'h7FFF : y[15:0];
    endfunction

    scr_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

    scr_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .radicand(sum65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum65[63:0]),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign prod        = mul_p[63:0];
    assign sum65       = {1'b0, acc_reg} + {1'b0, t_reg};
    assign sq_start    = (state_reg == S_SUM);
    assign thr16       = {cfg.threshold, 1'b0};
    assign one_minus_q = 17'h1_0000 - {1'b0, cfg.ratio};
    assign coef        = (at_reg > ae_reg) ? cfg.attack : cfg.release_c;
    assign one_minus_c = 17'h1_0000 - {1'b0, coef};
    assign q           = prod[61:30];
    assign lgr         = {lgn_reg, frac_reg};
    assign mix_sum     = acc_reg[40:0] + prod[40:0];
    assign r_shift     = r_reg >> anew_reg[21:16];
    assign env_raw     = (anew_reg[22:16] >= 7'd40) ? 24'd0 : r_shift[32:9];
    assign env_new     = (env_raw > ENV_ONE) ? ENV_ONE : env_raw;
    assign e16         = env_new[23:7];

    assign mag_l    = left_in[SAMPLE_W-1]  ? MAG_W'(0) - {1'b1, left_in}  : {1'b0, left_in};
    assign mag_r    = right_in[SAMPLE_W-1] ? MAG_W'(0) - {1'b1, right_in} : {1'b0, right_in};
    assign pair_sum = {left_in[SAMPLE_W-1], left_in} + {right_in[SAMPLE_W-1], right_in};
    assign mono_in  = pair_sum[MAG_W-1] ? MAG_W'(0) - pair_sum : pair_sum;

    // Leading-one search, halving the shift each cycle.
    always_comb begin
        nx = lgx_reg;
        nn = lgn_reg;
        unique case (cnt_reg[2:0])
            3'd0: if (lgx_reg[31:16] == '0) begin nx = lgx_reg << 16; nn = lgn_reg - 5'd16; end
            3'd1: if (lgx_reg[31:24] == '0) begin nx = lgx_reg << 8;  nn = lgn_reg - 5'd8;  end
            3'd2: if (lgx_reg[31:28] == '0) begin nx = lgx_reg << 4;  nn = lgn_reg - 5'd4;  end
            3'd3: if (lgx_reg[31:30] == '0) begin nx = lgx_reg << 2;  nn = lgn_reg - 5'd2;  end
            3'd4: if (!lgx_reg[31])         begin nx = lgx_reg << 1;  nn = lgn_reg - 5'd1;  end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_SQ;
            S_SQ:     state_next = S_AHI;
            S_AHI:    state_next = S_ALO;
            S_ALO:    state_next = S_MONO;
            S_MONO:   state_next = S_WT;
            S_WT:     state_next = S_SUM;
            S_SUM:    state_next = S_SQRT;
            S_SQRT: begin
                if (sq_done) begin
                    state_next = (sq_root > 32'(thr16) && thr16 != '0) ? S_LGN : S_ENVCHK;
                end
            end
            S_LGN:    if (cnt_reg == 5'd4)  state_next = S_LGS;
            S_LGS:    if (cnt_reg == 5'd15) state_next = S_LGD;
            S_LGD: begin
                unique case (lg_sel_reg)
                    LG_LEV:  state_next = S_LGN;
                    LG_THR:  state_next = S_ATT;
                    default: state_next = S_MIX1;
                endcase
            end
            S_ATT:    state_next = S_ENVCHK;
            S_ENVCHK: state_next = (env_reg == '0) ? S_MIX1 : S_LGN;
            S_MIX1:   state_next = S_MIX2;
            S_MIX2:   state_next = S_EXP;
            S_EXP:    if (cnt_reg == 5'd15) state_next = S_SHIFT;
            S_SHIFT:  state_next = S_GAIN;
            S_GAIN:   state_next = S_OUTL;
            S_OUTL:   state_next = S_OUTR;
            S_OUTR:   state_next = S_DONE;
            S_DONE:   if (res_take) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Operand routing for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ:   begin mul_a = {1'b0, dl_reg};          mul_b = dl_reg;                  end
            S_AHI:  begin mul_a = MUL_A_W'(t_reg[63:48]);  mul_b = MUL_B_W'(cfg.alpha);     end
            S_ALO:  begin mul_a = MUL_A_W'(t_reg[47:16]);  mul_b = MUL_B_W'(cfg.alpha);     end
            S_MONO: begin mul_a = MUL_A_W'(mono_reg);      mul_b = MUL_B_W'(mono_reg);      end
            S_WT:   begin mul_a = t_reg[32:0];             mul_b = MUL_B_W'(cfg.weight);    end
            S_LGS:  begin mul_a = {1'b0, m_reg};           mul_b = m_reg;                   end
            S_ATT:  begin mul_a = MUL_A_W'(t_reg[LOG_W-1:0]); mul_b = MUL_B_W'(one_minus_q); end
            S_MIX1: begin mul_a = MUL_A_W'(ae_reg);        mul_b = MUL_B_W'(one_minus_c);   end
            S_MIX2: begin mul_a = MUL_A_W'(at_reg);        mul_b = MUL_B_W'(coef);          end
            S_EXP:  begin mul_a = r_reg;                   mul_b = EXP_C[cnt_reg[3:0]];     end
            S_GAIN: begin mul_a = MUL_A_W'(cfg.makeup);    mul_b = MUL_B_W'(env_reg);       end
            S_OUTL: begin mul_a = MUL_A_W'(ml_reg);        mul_b = MUL_B_W'(g_reg);         end
            S_OUTR: begin mul_a = MUL_A_W'(mr_reg);        mul_b = MUL_B_W'(g_reg);         end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dl_reg    <= '0;
            env_reg   <= ENV_ONE;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_SQRT && sq_done) begin
                dl_reg <= sq_root;
            end
            if (state_reg == S_SHIFT) begin
                env_reg <= env_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                ml_reg   <= mag_l;
                mr_reg   <= mag_r;
                nl_reg   <= left_in[SAMPLE_W-1];
                nr_reg   <= right_in[SAMPLE_W-1];
                mono_reg <= mono_in;
            end
            S_SQ:   t_reg   <= prod;
            S_AHI:  acc_reg <= {prod[31:0], 32'd0};
            S_ALO:  acc_reg <= acc_reg + prod;
            S_MONO: t_reg   <= prod;
            S_WT:   t_reg   <= prod >> 14;
            S_SQRT: begin
                at_reg     <= (sq_root > 32'(thr16) && thr16 == '0) ? ATT_MAX : '0;
                lgx_reg    <= sq_root;
                lg_sel_reg <= LG_LEV;
                lgn_reg    <= 5'd31;
                cnt_reg    <= '0;
            end
            S_LGN: begin
                lgx_reg <= nx;
                lgn_reg <= nn;
                cnt_reg <= (cnt_reg == 5'd4) ? 5'd0 : cnt_reg + 5'd1;
                if (cnt_reg == 5'd4) begin
                    m_reg    <= {1'b0, nx[31:1]};
                    frac_reg <= '0;
                end
            end
            S_LGS: begin
                frac_reg <= {frac_reg[14:0], q[31]};
                m_reg    <= q[31] ? {1'b0, q[31:1]} : q;
                cnt_reg  <= cnt_reg + 5'd1;
            end
            S_LGD: begin
                unique case (lg_sel_reg)
                    LG_LEV: begin
                        ll_reg     <= lgr;
                        lgx_reg    <= 32'(thr16);
                        lg_sel_reg <= LG_THR;
                        lgn_reg    <= 5'd31;
                        cnt_reg    <= '0;
                    end
                    LG_THR:  t_reg  <= (ll_reg > lgr) ? 64'(ll_reg - lgr) : 64'd0;
                    default: ae_reg <= (ENV_LOG_ONE > lgr) ? ATT_W'(ENV_LOG_ONE - lgr) : '0;
                endcase
            end
            S_ATT: at_reg <= prod[ATT_W+15:16];
            S_ENVCHK: begin
                ae_reg     <= ATT_MAX;
                lgx_reg    <= 32'(env_reg);
                lg_sel_reg <= LG_ENV;
                lgn_reg    <= 5'd31;
                cnt_reg    <= '0;
            end
            S_MIX1: acc_reg <= prod;
            S_MIX2: begin
                anew_reg <= mix_sum[ATT_W+15:16];
                r_reg    <= 33'h1_0000_0000;
                cnt_reg  <= '0;
            end
            S_EXP: begin
                if (anew_reg[4'd15 - cnt_reg[3:0]]) begin
                    r_reg <= {1'b0, prod[63:32]};
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            S_SHIFT: env16_reg <= e16[16] ? 16'hFFFF : e16[15:0];
            S_GAIN:  g_reg     <= prod[38:23];
            S_OUTL:  out_l_reg <= sat_out(prod[31:12], nl_reg);
            S_OUTR:  out_r_reg <= sat_out(prod[31:12], nr_reg);
            default: ;
        endcase
    end

    assign idle         = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res.left     = out_l_reg;
    assign res.right    = out_r_reg;
    assign res.envelope = env16_reg;

endmodule

// ===== rtl/scr_checker.sv =====
`timescale 1ns / 1ps
`include "stereo_rms_compressor_assert.svh"

module scr_checker
    import scr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [SAMPLE_W-1:0] m_left_out,
    input logic [SAMPLE_W-1:0] m_right_out,
    input logic [15:0]         m_envelope_out
);

    // A stalled result beat keeps its payload.
    `SRC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_left_out) && $stable(m_right_out) && $stable(m_envelope_out))

    // Work on a pair spans many cycles, so the input closes right after a beat.
    `SRC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // No result can appear in the cycle right after a pair is taken.
    `SRC_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))

    // Reset leaves the output empty and the input open.
    `SRC_ASSERT_NEXT_ALWAYS(a_reset_state, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind stereo_rms_compressor scr_checker u_scr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_left_out    (m_left_out),
    .m_right_out   (m_right_out),
    .m_envelope_out(m_envelope_out)
);
